/* rtl/core/scls_pkg.sv */
`default_nettype none

package scls_pkg;

  localparam int BUFFER_DEPTH = 65536;
  localparam int BLOCK_SAMPLES = 128;
  localparam int QUEUE_DEPTH = 4;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int IDX_W = ADDR_W + 1;
  localparam int OFS_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int MODE_W = 4;
  localparam int SAMPLE_W = 16;
  localparam int POS_W = 48;
  localparam int CODE_W = 3;
  localparam int LEN_W = 17;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 4'd0,
    MODE_START_CAPTURE = 4'd1,
    MODE_SCHED_CAP_START = 4'd2,
    MODE_CANCEL = 4'd3,
    MODE_END_CAPTURE = 4'd4,
    MODE_SCHED_CAP_END = 4'd5,
    MODE_PLAY = 4'd6,
    MODE_SCHED_ONSET = 4'd7,
    MODE_STOP = 4'd8,
    MODE_SCHED_LENGTH = 4'd9,
    MODE_DISABLE = 4'd10,
    MODE_TOGGLE = 4'd11
  } mode_t;

  typedef enum logic [7:0] {
    ST_IDLE_NONE = 8'b0000_0001,
    ST_IDLE_LOOP = 8'b0000_0010,
    ST_WAIT_CAP_START = 8'b0000_0100,
    ST_CAPTURING = 8'b0000_1000,
    ST_WAIT_CAP_END = 8'b0001_0000,
    ST_PLAYING = 8'b0010_0000,
    ST_WAIT_LENGTH = 8'b0100_0000,
    ST_WAIT_ONSET = 8'b1000_0000
  } state_t;

  localparam logic [CODE_W-1:0] CODE_IDLE_NONE = 3'd0;
  localparam logic [CODE_W-1:0] CODE_IDLE_LOOP = 3'd1;
  localparam logic [CODE_W-1:0] CODE_WAIT_CAP_START = 3'd2;
  localparam logic [CODE_W-1:0] CODE_CAPTURING = 3'd3;
  localparam logic [CODE_W-1:0] CODE_WAIT_CAP_END = 3'd4;
  localparam logic [CODE_W-1:0] CODE_PLAYING = 3'd5;
  localparam logic [CODE_W-1:0] CODE_WAIT_LENGTH = 3'd6;
  localparam logic [CODE_W-1:0] CODE_WAIT_ONSET = 3'd7;

  typedef struct packed {
    logic write_en;
    logic read_en;
    logic read_hit;
    logic [ADDR_W-1:0] addr;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [CODE_W-1:0] state_code;
    logic enabled;
    logic [LEN_W-1:0] loop_length;
  } op_t;

  function automatic logic due(input logic [POS_W-1:0] target, input logic [POS_W-1:0] now);
    return (target != '0) && (now >= target);
  endfunction

  function automatic logic [CODE_W-1:0] state_code(input state_t st);
    logic [CODE_W-1:0] code;
    unique case (st)
      ST_IDLE_NONE: code = CODE_IDLE_NONE;
      ST_IDLE_LOOP: code = CODE_IDLE_LOOP;
      ST_WAIT_CAP_START: code = CODE_WAIT_CAP_START;
      ST_CAPTURING: code = CODE_CAPTURING;
      ST_WAIT_CAP_END: code = CODE_WAIT_CAP_END;
      ST_PLAYING: code = CODE_PLAYING;
      ST_WAIT_LENGTH: code = CODE_WAIT_LENGTH;
      ST_WAIT_ONSET: code = CODE_WAIT_ONSET;
      default: code = CODE_IDLE_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scls_if.sv */
`default_nettype none

interface scls_in_if;
  logic valid;
  logic ready;
  logic [scls_pkg::MODE_W-1:0] mode;
  logic signed [scls_pkg::SAMPLE_W-1:0] left_in;
  logic signed [scls_pkg::SAMPLE_W-1:0] right_in;
  logic [scls_pkg::POS_W-1:0] now_position;
  logic [scls_pkg::POS_W-1:0] target_position;
  logic held;

  modport source(
    output valid, mode, left_in, right_in, now_position, target_position, held,
    input ready
  );
  modport sink(
    input valid, mode, left_in, right_in, now_position, target_position, held,
    output ready
  );
endinterface

interface scls_out_if;
  logic valid;
  logic ready;
  logic signed [scls_pkg::SAMPLE_W-1:0] left_out;
  logic signed [scls_pkg::SAMPLE_W-1:0] right_out;
  logic [scls_pkg::CODE_W-1:0] machine_state;
  logic enabled;
  logic [scls_pkg::LEN_W-1:0] loop_length_out;

  modport source(
    output valid, left_out, right_out, machine_state, enabled, loop_length_out,
    input ready
  );
  modport sink(
    input valid, left_out, right_out, machine_state, enabled, loop_length_out,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/scls_ram.sv */
`default_nettype none

module scls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input wire logic clk,
  input wire logic we,
  input wire logic re,
  input wire logic [$clog2(DEPTH)-1:0] addr,
  input wire logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/scls_queue.sv */
`default_nettype none

module scls_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire scls_pkg::op_t push_op,
  input wire logic pop,
  output scls_pkg::op_t head,
  output logic full,
  output logic empty
);

  scls_pkg::op_t entries [scls_pkg::QUEUE_DEPTH];
  logic [scls_pkg::QPTR_W-1:0] wr_ptr;
  logic [scls_pkg::QPTR_W-1:0] rd_ptr;
  logic [scls_pkg::QCNT_W-1:0] count;

  assign full = (count == scls_pkg::QCNT_W'(scls_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + scls_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + scls_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + scls_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - scls_pkg::QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) |-> (empty || full))
    else $error("queue pointers meet while the queue is partly filled");

endmodule

`default_nettype wire

/* rtl/core/scls_front.sv */
`default_nettype none

module scls_front (
  input wire logic clk,
  input wire logic rst,
  scls_in_if.sink feed,
  input wire logic queue_full,
  output logic push,
  output scls_pkg::op_t push_op
);

  scls_pkg::state_t st, st_next;
  logic [scls_pkg::IDX_W-1:0] write_index, write_index_next;
  logic [scls_pkg::ADDR_W-1:0] read_index, read_index_next;
  logic [scls_pkg::IDX_W-1:0] loop_length, loop_length_next;
  logic [scls_pkg::IDX_W-1:0] high_water, high_water_next;
  logic [scls_pkg::POS_W-1:0] cap_start, cap_start_next;
  logic [scls_pkg::POS_W-1:0] cap_end, cap_end_next;
  logic [scls_pkg::POS_W-1:0] onset, onset_next;
  logic [scls_pkg::POS_W-1:0] length_tgt, length_tgt_next;
  logic held_flag, held_flag_next;
  logic [scls_pkg::OFS_W-1:0] block_offset, block_offset_next;
  logic en_now;

  assign feed.ready = !queue_full;
  assign push = feed.valid && !queue_full;
  assign en_now = (st != scls_pkg::ST_IDLE_NONE) && (st != scls_pkg::ST_IDLE_LOOP);

  always_comb begin
    st_next = st;
    write_index_next = write_index;
    read_index_next = read_index;
    loop_length_next = loop_length;
    high_water_next = high_water;
    cap_start_next = cap_start;
    cap_end_next = cap_end;
    onset_next = onset;
    length_tgt_next = length_tgt;
    held_flag_next = held_flag;
    block_offset_next = block_offset;
    push_op = '0;

    unique case (scls_pkg::mode_t'(feed.mode))
      scls_pkg::MODE_SAMPLE: begin
        if (block_offset == '0) begin
          if (scls_pkg::due(cap_start, feed.now_position)) begin
            write_index_next = '0;
            loop_length_next = '0;
            st_next = scls_pkg::ST_CAPTURING;
            cap_start_next = '0;
          end
          if (scls_pkg::due(cap_end, feed.now_position)) begin
            if (write_index_next != '0) begin
              loop_length_next = write_index_next;
              if (held_flag) begin
                read_index_next = '0;
                st_next = scls_pkg::ST_PLAYING;
              end else begin
                st_next = scls_pkg::ST_IDLE_LOOP;
              end
            end else begin
              st_next = scls_pkg::ST_IDLE_NONE;
            end
            cap_end_next = '0;
          end
          if (scls_pkg::due(onset, feed.now_position)) begin
            read_index_next = '0;
            st_next = scls_pkg::ST_PLAYING;
            onset_next = '0;
          end
          if (scls_pkg::due(length_tgt, feed.now_position)) begin
            st_next = scls_pkg::ST_IDLE_LOOP;
            length_tgt_next = '0;
          end
        end
        if (st_next == scls_pkg::ST_CAPTURING || st_next == scls_pkg::ST_WAIT_CAP_END) begin
          if (write_index_next < scls_pkg::IDX_W'(scls_pkg::BUFFER_DEPTH)) begin
            push_op.write_en = 1'b1;
            push_op.addr = write_index_next[scls_pkg::ADDR_W-1:0];
            if (write_index_next == high_water) begin
              high_water_next = high_water + scls_pkg::IDX_W'(1);
            end
            write_index_next = write_index_next + scls_pkg::IDX_W'(1);
          end
          if (block_offset == scls_pkg::OFS_W'(scls_pkg::BLOCK_SAMPLES - 1) &&
              write_index_next >= scls_pkg::IDX_W'(scls_pkg::BUFFER_DEPTH)) begin
            loop_length_next = write_index_next;
            if (held_flag) begin
              read_index_next = '0;
              st_next = scls_pkg::ST_PLAYING;
            end else begin
              st_next = scls_pkg::ST_IDLE_LOOP;
            end
            cap_end_next = '0;
          end
          push_op.left = feed.left_in;
          push_op.right = feed.right_in;
        end else if (st_next == scls_pkg::ST_PLAYING || st_next == scls_pkg::ST_WAIT_LENGTH) begin
          push_op.read_en = 1'b1;
          push_op.addr = read_index_next;
          push_op.read_hit = scls_pkg::IDX_W'(read_index_next) < high_water;
          if (scls_pkg::IDX_W'(read_index_next) + scls_pkg::IDX_W'(1) >= loop_length_next) begin
            read_index_next = '0;
          end else begin
            read_index_next = read_index_next + scls_pkg::ADDR_W'(1);
          end
        end else begin
          push_op.left = feed.left_in;
          push_op.right = feed.right_in;
        end
        if (block_offset == scls_pkg::OFS_W'(scls_pkg::BLOCK_SAMPLES - 1)) begin
          block_offset_next = '0;
        end else begin
          block_offset_next = block_offset + scls_pkg::OFS_W'(1);
        end
      end
      scls_pkg::MODE_START_CAPTURE: begin
        write_index_next = '0;
        loop_length_next = '0;
        st_next = scls_pkg::ST_CAPTURING;
      end
      scls_pkg::MODE_SCHED_CAP_START: begin
        cap_start_next = feed.target_position;
        st_next = scls_pkg::ST_WAIT_CAP_START;
      end
      scls_pkg::MODE_CANCEL: begin
        cap_start_next = '0;
        st_next = scls_pkg::ST_IDLE_NONE;
      end
      scls_pkg::MODE_END_CAPTURE: begin
        if (write_index != '0) begin
          loop_length_next = write_index;
          if (feed.held) begin
            read_index_next = '0;
            st_next = scls_pkg::ST_PLAYING;
          end else begin
            st_next = scls_pkg::ST_IDLE_LOOP;
          end
        end else begin
          st_next = scls_pkg::ST_IDLE_NONE;
        end
      end
      scls_pkg::MODE_SCHED_CAP_END: begin
        cap_end_next = feed.target_position;
        held_flag_next = feed.held;
        if (st == scls_pkg::ST_CAPTURING) begin
          st_next = scls_pkg::ST_WAIT_CAP_END;
        end
      end
      scls_pkg::MODE_PLAY: begin
        read_index_next = '0;
        st_next = scls_pkg::ST_PLAYING;
      end
      scls_pkg::MODE_SCHED_ONSET: begin
        onset_next = feed.target_position;
        st_next = scls_pkg::ST_WAIT_ONSET;
      end
      scls_pkg::MODE_STOP: begin
        st_next = scls_pkg::ST_IDLE_LOOP;
      end
      scls_pkg::MODE_SCHED_LENGTH: begin
        length_tgt_next = feed.target_position;
        if (st == scls_pkg::ST_PLAYING) begin
          st_next = scls_pkg::ST_WAIT_LENGTH;
        end
      end
      scls_pkg::MODE_DISABLE: begin
        st_next = scls_pkg::ST_IDLE_NONE;
        loop_length_next = '0;
        write_index_next = '0;
        read_index_next = '0;
      end
      scls_pkg::MODE_TOGGLE: begin
        if (en_now) begin
          st_next = scls_pkg::ST_IDLE_NONE;
          loop_length_next = '0;
          write_index_next = '0;
          read_index_next = '0;
        end else begin
          read_index_next = '0;
          st_next = scls_pkg::ST_PLAYING;
        end
      end
      default: begin
      end
    endcase

    push_op.state_code = scls_pkg::state_code(st_next);
    push_op.enabled = (st_next != scls_pkg::ST_IDLE_NONE) &&
                      (st_next != scls_pkg::ST_IDLE_LOOP);
    push_op.loop_length = scls_pkg::LEN_W'(loop_length_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= scls_pkg::ST_IDLE_NONE;
      write_index <= '0;
      read_index <= '0;
      loop_length <= '0;
      high_water <= '0;
      cap_start <= '0;
      cap_end <= '0;
      onset <= '0;
      length_tgt <= '0;
      held_flag <= 1'b0;
      block_offset <= '0;
    end else if (push) begin
      st <= st_next;
      write_index <= write_index_next;
      read_index <= read_index_next;
      loop_length <= loop_length_next;
      high_water <= high_water_next;
      cap_start <= cap_start_next;
      cap_end <= cap_end_next;
      onset <= onset_next;
      length_tgt <= length_tgt_next;
      held_flag <= held_flag_next;
      block_offset <= block_offset_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) write_index <= high_water)
    else $error("capture position runs past the written part of the store");

  assert property (@(posedge clk) disable iff (rst)
    (st == scls_pkg::ST_PLAYING || st == scls_pkg::ST_WAIT_LENGTH) |->
    (read_index == '0 || scls_pkg::IDX_W'(read_index) < loop_length))
    else $error("playback position lies outside the loop");

  assert property (@(posedge clk) disable iff (rst)
    push |-> !(push_op.write_en && push_op.read_en))
    else $error("one word asks for both a store write and a store read");

endmodule

`default_nettype wire

/* rtl/core/scls_back.sv */
`default_nettype none

module scls_back (
  input wire logic clk,
  input wire logic rst,
  input wire scls_pkg::op_t head,
  input wire logic queue_empty,
  output logic pop,
  scls_out_if.source result
);

  localparam int WORD_W = 2 * scls_pkg::SAMPLE_W;

  logic out_valid;
  scls_pkg::op_t out_op;
  logic [WORD_W-1:0] rdata;

  assign pop = !queue_empty && (!out_valid || result.ready);

  scls_ram #(
    .WIDTH(WORD_W),
    .DEPTH(scls_pkg::BUFFER_DEPTH)
  ) u_store (
    .clk(clk),
    .we(pop && head.write_en),
    .re(pop && head.read_en),
    .addr(head.addr),
    .wdata({head.left, head.right}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_op <= head;
    end
  end

  always_comb begin
    result.valid = out_valid;
    if (out_op.read_en) begin
      result.left_out = out_op.read_hit ? rdata[WORD_W-1:scls_pkg::SAMPLE_W] : '0;
      result.right_out = out_op.read_hit ? rdata[scls_pkg::SAMPLE_W-1:0] : '0;
    end else begin
      result.left_out = out_op.left;
      result.right_out = out_op.right;
    end
    result.machine_state = out_op.state_code;
    result.enabled = out_op.enabled;
    result.loop_length_out = out_op.loop_length;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=>
    (out_valid && $stable(result.left_out) && $stable(result.right_out)))
    else $error("result samples changed under a stalled word");

endmodule

`default_nettype wire

/* rtl/core/stereo_capture_loop_stutter.sv */
// Channel  Modport  Word
// feed     sink     mode, left_in, right_in, now_position, target_position, held
// result   source   left_out, right_out, machine_state, enabled, loop_length_out
//
// Words pass the front, then the back; one word per cycle is sustained unless result stalls.
// An accepted word is registered in the queue, then in the back along with its store read.
// The single-port sample store does one write or one read per word.
// The front stalls only when its four-entry queue is full; the back stalls on result.ready.
// Reset clears all control state at once; the store needs no clearing pass.
`default_nettype none

module stereo_capture_loop_stutter (
  input wire logic clk,
  input wire logic rst,
  scls_in_if.sink feed,
  scls_out_if.source result
);

  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  scls_pkg::op_t push_op;
  scls_pkg::op_t head;

  scls_front u_front (
    .clk(clk),
    .rst(rst),
    .feed(feed),
    .queue_full(queue_full),
    .push(push),
    .push_op(push_op)
  );

  scls_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_op(push_op),
    .pop(pop),
    .head(head),
    .full(queue_full),
    .empty(queue_empty)
  );

  scls_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .queue_empty(queue_empty),
    .pop(pop),
    .result(result)
  );

endmodule

`default_nettype wire
